// ===== rtl/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// NTC thermistor package
// Shared constants, resistance table and codes for the temperature pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ntc_pkg;

    // Resistance word, quotient of the resistance divider (1/16 ohm)
    localparam int R_W    = 40;
    // Table entry and neighbor span widths
    localparam int TBL_W  = 20;
    localparam int SPAN_W = 17;
    localparam int TBL_N  = 31;
    localparam int TIDX_W = 5;

    typedef logic [1:0] t_status;

    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_LOW  = 2'd1;
    localparam t_status ST_HIGH = 2'd2;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_UNITS  = 2'd0;
    localparam t_cfg_index CFG_VREF   = 2'd1;
    localparam t_cfg_index CFG_SERIES = 2'd2;

    localparam logic [15:0] VREF_RESET   = 16'd2500;
    localparam logic [19:0] SERIES_RESET = 20'd8200;

    // Clamp values in Celsius Q8
    localparam int LOW_CLAMP_Q8  = -2560;
    localparam int HIGH_CLAMP_Q8 = 40960;
    // Fahrenheit offset of 32 degrees in Q8
    localparam int F_OFFSET_Q8   = 8192;

    // NTC resistance in 1/16 ohm, one entry per step starting at 0 C
    localparam logic [TBL_W-1:0] RES_TABLE [0:TBL_N-1] = '{
        20'd522400, 20'd406240, 20'd318400, 20'd251360, 20'd199840, 20'd160000,
        20'd128912, 20'd104496, 20'd85232,  20'd69904,  20'd57648,  20'd47776,
        20'd39808,  20'd33328,  20'd28032,  20'd23696,  20'd20128,  20'd17152,
        20'd14683,  20'd12616,  20'd10880,  20'd9418,   20'd8179,   20'd7126,
        20'd6229,   20'd5467,   20'd4814,   20'd4246,   20'd3757,   20'd3333,
        20'd2965
    };

endpackage

`default_nettype wire

// ===== rtl/ntc_div.sv =====
// ----------------------------------------------------------------------------
// NTC pipelined divider
// Restoring divider, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_div #(
    parameter int NUM_W = 40,
    parameter int DEN_W = 16,
    parameter int QUO_W = 40,
    parameter int SB_W  = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    input  wire logic [SB_W-1:0]  i_sb,
    output logic                  o_valid,
    output logic [QUO_W-1:0]      o_quo,
    output logic [SB_W-1:0]       o_sb
);

    localparam int WW = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

    logic [WW-1:0]    r_rem [QUO_W];
    logic [DEN_W-1:0] r_den [QUO_W];
    logic [QUO_W-1:0] r_quo [QUO_W];
    logic [SB_W-1:0]  r_sb  [QUO_W];
    logic             r_vld [QUO_W];

    for (genvar s = 0; s < QUO_W; s++) begin : g_stage
        localparam int B = QUO_W - 1 - s;

        logic [WW-1:0]    rem_in;
        logic [DEN_W-1:0] den_in;
        logic [QUO_W-1:0] quo_in;
        logic [SB_W-1:0]  sb_in;
        logic             vld_in;
        logic [WW-1:0]    dsh;
        logic             ge;

        if (s == 0) begin : g_first
            assign rem_in = WW'(i_num);
            assign den_in = i_den;
            assign quo_in = '0;
            assign sb_in  = i_sb;
            assign vld_in = i_valid;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
            assign sb_in  = r_sb[s-1];
            assign vld_in = r_vld[s-1];
        end

        // Trial subtract of the shifted divisor
        assign dsh = WW'(den_in) << B;
        assign ge  = (rem_in >= dsh);

        // Advance one quotient bit
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= ge ? rem_in - dsh : rem_in;
                r_den[s] <= den_in;
                r_quo[s] <= ge ? (quo_in | (QUO_W'(1) << B)) : quo_in;
                r_sb[s]  <= sb_in;
            end
        end
    end

    assign o_valid = r_vld[QUO_W-1];
    assign o_quo   = r_quo[QUO_W-1];
    assign o_sb    = r_sb[QUO_W-1];

endmodule

`default_nettype wire

// ===== rtl/ntc_lookup.sv =====
// ----------------------------------------------------------------------------
// NTC table lookup
// Compares the resistance against the table, finds the segment and forms the
// interpolation dividend and span.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_lookup import ntc_pkg::*; #(
    parameter int CNT     = 31,
    parameter int IDX_W   = 5,
    parameter int S256    = 1280,
    parameter int NUM2_W  = 28
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [R_W-1:0]    i_r,
    input  wire logic              i_open,
    output logic                   o_valid,
    output logic [NUM2_W-1:0]      o_num,
    output logic [SPAN_W-1:0]      o_span,
    output logic [IDX_W-1:0]       o_idx,
    output t_status                o_status
);

    // Stage 1: compare against every entry
    logic             r1_valid;
    logic [CNT-1:0]   r1_gt;
    logic             r1_open;
    logic [TBL_W-1:0] r1_r;

    logic [CNT-1:0] gt;
    for (genvar j = 0; j < CNT; j++) begin : g_cmp
        assign gt[j] = R_W'(RES_TABLE[j]) > i_r;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_gt   <= gt;
            r1_open <= i_open;
            r1_r    <= i_r[TBL_W-1:0];
        end
    end

    // Stage 2: first entry at or below the resistance
    logic             r2_valid;
    logic [IDX_W-1:0] r2_idx;
    t_status          r2_status;
    logic [TBL_W-1:0] r2_r;

    logic [IDX_W-1:0] idx;
    t_status          status;

    always_comb begin
        idx = IDX_W'(CNT);
        for (int j = CNT - 1; j >= 0; j--) begin
            if (!r1_gt[j]) begin
                idx = IDX_W'(j);
            end
        end
        if (r1_open || idx == '0) begin
            status = ST_LOW;
        end else if (idx == IDX_W'(CNT)) begin
            status = ST_HIGH;
        end else begin
            status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_idx    <= idx;
            r2_status <= status;
            r2_r      <= r1_r;
        end
    end

    // Stage 3: offset into segment and rounded dividend
    logic              r3_valid;
    logic [NUM2_W-1:0] r3_num;
    logic [SPAN_W-1:0] r3_span;
    logic [IDX_W-1:0]  r3_idx;
    t_status           r3_status;

    logic [TBL_W-1:0]  lo;
    logic [TBL_W-1:0]  hi;
    logic [TBL_W-1:0]  dfull;
    logic [TBL_W-1:0]  sfull;
    logic [SPAN_W-1:0] span;
    logic [NUM2_W-1:0] num;

    always_comb begin
        lo    = RES_TABLE[TIDX_W'(r2_idx)];
        hi    = RES_TABLE[TIDX_W'(r2_idx - 1'b1)];
        dfull = r2_r - lo;
        sfull = hi - lo;
        if (r2_status == ST_OK) begin
            span = sfull[SPAN_W-1:0];
            num  = NUM2_W'(dfull[SPAN_W-1:0]) * NUM2_W'(S256)
                 + NUM2_W'(sfull[SPAN_W-1:1]);
        end else begin
            span = SPAN_W'(1);
            num  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_num    <= num;
            r3_span   <= span;
            r3_idx    <= r2_idx;
            r3_status <= r2_status;
        end
    end

    assign o_valid  = r3_valid;
    assign o_num    = r3_num;
    assign o_span   = r3_span;
    assign o_idx    = r3_idx;
    assign o_status = r3_status;

endmodule

`default_nettype wire

// ===== rtl/ntc_units.sv =====
// ----------------------------------------------------------------------------
// NTC unit conversion
// Builds the Celsius Q8 value, converts to Fahrenheit when selected and saturates.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_units import ntc_pkg::*; #(
    parameter int IDX_W  = 5,
    parameter int FRAC_W = 11,
    parameter int S256   = 1280,
    parameter int CW     = 17
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_units,
    input  wire logic              i_valid,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire t_status           i_status,
    input  wire logic [FRAC_W-1:0] i_frac,
    output logic                   o_valid,
    output logic signed [17:0]     o_temperature,
    output t_status                o_status
);

    localparam int MW = CW + 3;
    localparam int K  = MW + 2;
    localparam int TW = MW + 2;
    localparam longint unsigned RECIP = ((64'd1 << K) + 64'd4) / 64'd5;

    // Stage 1: Celsius value
    logic                 r1_valid;
    logic signed [CW-1:0] r1_c;
    t_status              r1_status;

    logic signed [CW-1:0] c;
    always_comb begin
        case (i_status)
            ST_LOW:  c = CW'(LOW_CLAMP_Q8);
            ST_HIGH: c = CW'(HIGH_CLAMP_Q8);
            default: c = $signed(CW'(i_idx) * CW'(S256)) - $signed(CW'(i_frac));
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c      <= c;
            r1_status <= i_status;
        end
    end

    // Stage 2: magnitude times nine plus rounding bias
    logic                 r2_valid;
    logic [MW-1:0]        r2_m;
    logic                 r2_neg;
    logic signed [CW-1:0] r2_c;
    t_status              r2_status;

    logic [CW-1:0] mag;
    assign mag = r1_c[CW-1] ? CW'(-r1_c) : CW'(r1_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_m      <= MW'(mag) * MW'(9) + MW'(2);
            r2_neg    <= r1_c[CW-1];
            r2_c      <= r1_c;
            r2_status <= r1_status;
        end
    end

    // Stage 3: divide by five through the reciprocal
    logic                 r3_valid;
    logic [MW+K-1:0]      r3_prod;
    logic                 r3_neg;
    logic signed [CW-1:0] r3_c;
    t_status              r3_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_prod   <= (MW+K)'(r2_m) * (MW+K)'(RECIP);
            r3_neg    <= r2_neg;
            r3_c      <= r2_c;
            r3_status <= r2_status;
        end
    end

    // Stage 4: sign, offset, unit select and saturation
    logic                 r4_valid;
    logic signed [17:0]   r4_temp;
    t_status              r4_status;

    logic [MW-1:0]        q;
    logic signed [TW-1:0] qs;
    logic signed [TW-1:0] t;
    logic signed [17:0]   sat;

    always_comb begin
        q  = r3_prod[MW+K-1:K];
        qs = $signed({2'b00, q});
        if (i_units) begin
            t = (r3_neg ? -qs : qs) + TW'(F_OFFSET_Q8);
        end else begin
            t = TW'(r3_c);
        end
        if (t > TW'(131071)) begin
            sat = 18'sd131071;
        end else if (t < -TW'(131072)) begin
            sat = -18'sd131072;
        end else begin
            sat = t[17:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_temp   <= sat;
            r4_status <= r3_status;
        end
    end

    assign o_valid       = r4_valid;
    assign o_temperature = r4_temp;
    assign o_status      = r4_status;

endmodule

`default_nettype wire

// ===== rtl/ntc_thermistor_temperature.sv =====
// ----------------------------------------------------------------------------
// NTC thermistor temperature converter
// ADC millivolts to temperature by table interpolation, Celsius or Fahrenheit.
// ----------------------------------------------------------------------------
// One reading enters per clock and one result leaves per clock while the output
// is not stalled. The pipeline contains two bit-per-stage restoring dividers, one
// for the thermistor resistance (40 quotient bits) and one for the interpolation
// fraction. The whole pipeline holds while the output is stalled. Write
// configuration only while no reading is in flight.
`default_nettype none

module ntc_thermistor_temperature import ntc_pkg::*; #(
    parameter int TABLE_ENTRIES    = 31,
    parameter int DEGREES_PER_STEP = 5
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_stall,
    input  wire logic [15:0]  i_adc_millivolts,
    output logic              o_valid,
    input  wire logic         i_stall,
    output logic signed [17:0] o_temperature,
    output logic [1:0]        o_range_status,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [19:0]  i_cfg_data
);

    localparam int CNT     = (TABLE_ENTRIES > TBL_N) ? TBL_N : TABLE_ENTRIES;
    localparam int IDX_W   = $clog2(CNT + 1);
    localparam int S256    = DEGREES_PER_STEP * 256;
    localparam int FRAC_W  = $clog2(S256 + 1);
    localparam int NUM2_W  = SPAN_W + FRAC_W;
    localparam int BASE_W  = $clog2(CNT * S256 + 1);
    localparam int CW      = ((BASE_W > 16) ? BASE_W : 16) + 1;

    // Configuration registers
    logic        r_units;
    logic [15:0] r_vref;
    logic [19:0] r_series;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_units  <= 1'b0;
            r_vref   <= VREF_RESET;
            r_series <= SERIES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_UNITS:  r_units  <= i_cfg_data[0];
                CFG_VREF:   r_vref   <= i_cfg_data[15:0];
                CFG_SERIES: r_series <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // Global advance: hold everything while the output transfer is stalled
    logic en;
    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    // Stage 1: open-sensor check and divisor
    logic        r1_valid;
    logic [15:0] r1_v;
    logic        r1_open;
    logic [15:0] r1_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (en) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_v    <= i_adc_millivolts;
            r1_open <= (i_adc_millivolts >= r_vref);
            r1_den  <= (i_adc_millivolts >= r_vref) ? 16'd1 : r_vref - i_adc_millivolts;
        end
    end

    // Stage 2: dividend v * series * 16
    logic           r2_valid;
    logic [R_W-1:0] r2_num;
    logic [15:0]    r2_den;
    logic           r2_open;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (en) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_num  <= (R_W'(r1_v) * R_W'(r_series)) << 4;
            r2_den  <= r1_den;
            r2_open <= r1_open;
        end
    end

    // Resistance divider
    logic           d1_valid;
    logic [R_W-1:0] d1_r;
    logic           d1_open;

    ntc_div #(
        .NUM_W (R_W),
        .DEN_W (16),
        .QUO_W (R_W),
        .SB_W  (1)
    ) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_valid),
        .i_num   (r2_num),
        .i_den   (r2_den),
        .i_sb    (r2_open),
        .o_valid (d1_valid),
        .o_quo   (d1_r),
        .o_sb    (d1_open)
    );

    // Table search and interpolation operands
    logic              lk_valid;
    logic [NUM2_W-1:0] lk_num;
    logic [SPAN_W-1:0] lk_span;
    logic [IDX_W-1:0]  lk_idx;
    t_status           lk_status;

    ntc_lookup #(
        .CNT    (CNT),
        .IDX_W  (IDX_W),
        .S256   (S256),
        .NUM2_W (NUM2_W)
    ) u_lookup (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (d1_valid),
        .i_r      (d1_r),
        .i_open   (d1_open),
        .o_valid  (lk_valid),
        .o_num    (lk_num),
        .o_span   (lk_span),
        .o_idx    (lk_idx),
        .o_status (lk_status)
    );

    // Fraction divider
    logic              d2_valid;
    logic [FRAC_W-1:0] d2_frac;
    logic [IDX_W-1:0]  d2_idx;
    t_status           d2_status;

    ntc_div #(
        .NUM_W (NUM2_W),
        .DEN_W (SPAN_W),
        .QUO_W (FRAC_W),
        .SB_W  (IDX_W + 2)
    ) u_div_f (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (lk_valid),
        .i_num   (lk_num),
        .i_den   (lk_span),
        .i_sb    ({lk_idx, lk_status}),
        .o_valid (d2_valid),
        .o_quo   (d2_frac),
        .o_sb    ({d2_idx, d2_status})
    );

    // Unit conversion and output register
    ntc_units #(
        .IDX_W  (IDX_W),
        .FRAC_W (FRAC_W),
        .S256   (S256),
        .CW     (CW)
    ) u_units (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_units       (r_units),
        .i_valid       (d2_valid),
        .i_idx         (d2_idx),
        .i_status      (d2_status),
        .i_frac        (d2_frac),
        .o_valid       (o_valid),
        .o_temperature (o_temperature),
        .o_status      (o_range_status)
    );

    // Checks
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_range_status != 2'd3))
        else $error("invalid range status");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |-> o_stall)
        else $error("input taken while output stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ===== sim/ntc_checker.sv =====
// ----------------------------------------------------------------------------
// NTC converter result checker
// Watches the reading and result channels and the register port, predicts
// each temperature and range status, and compares them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_checker import ntc_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_in_stall,
    input  wire logic [15:0]       i_adc_millivolts,
    input  wire logic              i_out_valid,
    input  wire logic              i_out_stall,
    input  wire logic signed [17:0] i_temperature,
    input  wire logic [1:0]        i_range_status,
    input  wire logic              i_cfg_valid,
    input  wire logic              i_cfg_ready,
    input  wire logic [1:0]        i_cfg_index,
    input  wire logic [19:0]       i_cfg_data,
    output int                     o_errors,
    output int                     o_pending,
    output int                     o_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic signed [17:0] temp;
        t_status            status;
    } t_reading;

    logic        fahrenheit;
    logic [15:0] vref_mv;
    logic [19:0] series;
    t_reading    expected_q[$];

    // Convert one reading with the current register values
    function automatic t_reading convert_reading(logic [15:0] adc);
        t_reading res;
        longint   r;
        longint   c_q8;
        longint   n;
        longint   span;
        longint   t;
        int       i;
        if (adc >= vref_mv) begin
            c_q8 = LOW_CLAMP_Q8;
            res.status = ST_LOW;
        end else begin
            r = (longint'(adc) * longint'(series) * 16) / (longint'(vref_mv) - adc);
            i = 0;
            while (i < TBL_N && longint'(RES_TABLE[i]) > r) i++;
            if (i == 0) begin
                c_q8 = LOW_CLAMP_Q8;
                res.status = ST_LOW;
            end else if (i >= TBL_N) begin
                c_q8 = HIGH_CLAMP_Q8;
                res.status = ST_HIGH;
            end else begin
                span = longint'(RES_TABLE[i-1]) - longint'(RES_TABLE[i]);
                c_q8 = longint'(i) * 5 * 256
                     - ((r - RES_TABLE[i]) * 5 * 256 + span / 2) / span;
                res.status = ST_OK;
            end
        end
        t = c_q8;
        if (fahrenheit) begin
            n = c_q8 * 9;
            t = (n >= 0) ? (n + 2) / 5 : -((-n + 2) / 5);
            t = t + F_OFFSET_Q8;
        end
        if (t > 131071) t = 131071;
        if (t < -131072) t = -131072;
        res.temp = t[17:0];
        return res;
    endfunction

    // Track registers, queue predictions, compare transfers
    always @(posedge i_clk) begin
        t_reading got;
        t_reading want;
        if (!i_rst_n) begin
            fahrenheit <= 1'b0;
            vref_mv    <= VREF_RESET;
            series     <= SERIES_RESET;
            expected_q.delete();
            o_errors  <= 0;
            o_results <= 0;
        end else begin
            if (i_valid && !i_in_stall)
                expected_q.push_back(convert_reading(i_adc_millivolts));
            if (i_out_valid && !i_out_stall) begin
                got.temp   = i_temperature;
                got.status = i_range_status;
                o_results <= o_results + 1;
                if (expected_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected result temp=%0d status=%0d",
                                 got.temp, got.status);
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        if (o_errors < 10)
                            $display("mismatch: expected temp=%0d status=%0d, got temp=%0d status=%0d",
                                     want.temp, want.status, got.temp, got.status);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_UNITS:  fahrenheit <= i_cfg_data[0];
                    CFG_VREF:   vref_mv <= i_cfg_data[15:0];
                    CFG_SERIES: series <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_comb o_pending = expected_q.size();

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// NTC converter testbench top
// Drives readings and register writes under random gaps and output stalls,
// including one long output hold-off, and reports the checker's verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import ntc_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [15:0]       adc_mv;
    logic              out_valid;
    logic              out_stall;
    logic signed [17:0] temperature;
    logic [1:0]        range_status;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [1:0]        cfg_index;
    logic [19:0]       cfg_data;
    int                errors;
    int                pending;
    int                results;
    logic              hold_off;
    logic [15:0]       cur_vref;

    ntc_thermistor_temperature dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall), .i_adc_millivolts(adc_mv),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_temperature(temperature), .o_range_status(range_status),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    ntc_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_in_stall(in_stall), .i_adc_millivolts(adc_mv),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_temperature(temperature), .i_range_status(range_status),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Output stall: random per transfer, with one long hold-off on request
    initial begin
        int waits;
        out_stall = 1'b1;
        forever begin
            if (hold_off) begin
                out_stall <= 1'b1;
                repeat (400) @(negedge clk);
                hold_off = 1'b0;
            end
            waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
            if (waits > 0) begin
                out_stall <= 1'b1;
                repeat (waits) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    // Offer one reading, with a random gap first when allowed
    task automatic send_reading(logic [15:0] mv, bit gaps);
        int waits;
        waits = gaps ? $urandom_range(0, 13) : 0;
        if (waits > 0) begin
            in_valid <= 1'b0;
            repeat (waits) @(negedge clk);
        end
        in_valid <= 1'b1;
        adc_mv   <= mv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    // Drain results, then let the pipeline settle before a register write
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic write_register(t_cfg_index idx, logic [19:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_VREF) cur_vref = val[15:0];
    endtask

    // Mostly readings below vref (interpolated region), some anywhere
    function automatic logic [15:0] pick_reading();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return cur_vref - 16'($urandom_range(0, 3));
            2: return 16'($urandom_range(0, 5));
            default: return (cur_vref > 1) ? 16'($urandom_range(0, cur_vref - 1)) : 16'd0;
        endcase
    endfunction

    initial begin
        logic [19:0] vrefs [5];
        logic [19:0] series_vals [5];
        int phase;
        vrefs       = '{20'd2500, 20'd1, 20'd65535, 20'd3300, 20'd5000};
        series_vals = '{20'd8200, 20'd1, 20'd1048575, 20'd10000, 20'd4700};
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        adc_mv    = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_UNITS;
        cfg_data  = '0;
        hold_off  = 1'b0;
        cur_vref  = VREF_RESET;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, edges of the reading and the table ends
        send_reading(16'd0, 0);
        send_reading(16'd65535, 0);
        send_reading(16'd2500, 0);
        send_reading(16'd2499, 0);
        send_reading(16'd2400, 0);
        send_reading(16'd1250, 0);
        send_reading(16'd500, 0);
        send_reading(16'd200, 0);
        send_reading(16'd100, 0);
        send_reading(16'd1, 0);
        send_reading(16'hAAAA, 0);
        send_reading(16'h5555, 0);
        drain_pipeline();
        write_register(CFG_UNITS, 20'd1);
        send_reading(16'd0, 0);
        send_reading(16'd2499, 0);
        send_reading(16'd1000, 0);
        send_reading(16'd300, 0);
        drain_pipeline();

        // Random phases over register settings, long hold-off in phase 1
        for (phase = 0; phase < 10; phase++) begin
            write_register(CFG_UNITS, 20'($urandom_range(0, 1)));
            write_register(CFG_VREF, (phase < 5) ? vrefs[phase]
                                                 : 20'($urandom_range(1, 65535)));
            write_register(CFG_SERIES, (phase < 5) ? series_vals[phase]
                                                   : 20'($urandom_range(1, 1000000)));
            if (phase == 1) hold_off = 1'b1;
            repeat (170) send_reading(pick_reading(), $urandom_range(0, 2) != 0);
            drain_pipeline();
        end
        write_register(CFG_VREF, 20'd0);
        write_register(CFG_SERIES, 20'd0);
        send_reading(16'd0, 0);
        send_reading(16'd7, 0);
        drain_pipeline();

        $display("Converted %0d readings across ten register settings, both units,", results);
        $display("open sensor, table clamps and a long output hold-off.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/ntc_pkg.sv
rtl/ntc_div.sv
rtl/ntc_lookup.sv
rtl/ntc_units.sv
rtl/ntc_thermistor_temperature.sv
sim/ntc_checker.sv
sim/tb_top.sv
